// ===== rtl/hcem_pkg.sv =====
// ----------------------------------------------------------------------------
// hcem_pkg: shared types and constants of the cohort event matcher
// Field widths, hash constants, the command and result records passed
// between the front, the queue and the back, and the state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package hcem_pkg;

    // Field widths
    localparam int ENTRY_W   = 3;
    localparam int TRIG_W    = 32;
    localparam int BOUND_W   = 54;
    localparam int UID_W     = 64;
    localparam int COUNT_W   = 32;
    localparam int BUCKET_W  = 53;
    localparam int ACTIVE_W  = 4;
    localparam int MAX_ENTRY = 2 ** ENTRY_W;

    // Stream word widths
    localparam int S_DATA_W = 240;
    localparam int M_DATA_W = 96;

    // SplitMix64 finalizer constants
    localparam logic [UID_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [UID_W-1:0] MIX_MUL_1    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [UID_W-1:0] MIX_MUL_2    = 64'h94D0_49BB_1331_11EB;
    localparam int SHIFT_PRE   = 30;
    localparam int SHIFT_MID   = 27;
    localparam int SHIFT_POST  = 31;
    localparam int SHIFT_OUT   = 11;

    // 1.0 scaled by 2^53
    localparam logic [BOUND_W-1:0] ONE_SCALED = 54'h20_0000_0000_0000;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // Classified item travelling from the front to the back
    typedef struct packed {
        action_t              action;
        logic [ENTRY_W-1:0]   entry_index;
        logic [TRIG_W-1:0]    trigger_count;
        logic [BOUND_W-1:0]   cohort_low;
        logic [BOUND_W-1:0]   cohort_high;
        logic [UID_W-1:0]     user_id;
        logic [COUNT_W-1:0]   interaction_count;
        logic                 write_error;
    } cmd_t;

    // One result word
    typedef struct packed {
        logic                 write_error;
        logic [BUCKET_W-1:0]  user_bucket;
        logic [TRIG_W-1:0]    earliest_trigger;
        logic                 in_any_cohort;
        logic [ENTRY_W-1:0]   matched_event;
        logic                 applied;
    } result_t;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_MUL_LL,
        HS_MUL_HL,
        HS_MUL_LH,
        HS_MIX
    } hash_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HASH,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/hcem_front.sv =====
// ----------------------------------------------------------------------------
// hcem_front: input stage
// Accepts input words, unpacks and classifies them, flags faulty cohort
// ranges on writes and holds the classified command until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcem_front
    import hcem_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tuser,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output cmd_t                     cmd
);

    localparam int OFS_TRIG  = ENTRY_W;
    localparam int OFS_LOW   = OFS_TRIG + TRIG_W;
    localparam int OFS_HIGH  = OFS_LOW + BOUND_W;
    localparam int OFS_UID   = OFS_HIGH + BOUND_W;
    localparam int OFS_COUNT = OFS_UID + UID_W;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_in;

    // Unpack the word and check the written range.
    always_comb begin
        cmd_in.action            = action_t'(s_tuser);
        cmd_in.entry_index       = s_tdata[ENTRY_W-1:0];
        cmd_in.trigger_count     = s_tdata[OFS_TRIG +: TRIG_W];
        cmd_in.cohort_low        = s_tdata[OFS_LOW +: BOUND_W];
        cmd_in.cohort_high       = s_tdata[OFS_HIGH +: BOUND_W];
        cmd_in.user_id           = s_tdata[OFS_UID +: UID_W];
        cmd_in.interaction_count = s_tdata[OFS_COUNT +: COUNT_W];
        cmd_in.write_error       = (cmd_in.action == ACT_WRITE) &&
                                   ((cmd_in.cohort_low >= cmd_in.cohort_high) ||
                                    (cmd_in.cohort_high > ONE_SCALED));
    end

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Holding register in front of the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hcem_queue.sv =====
// ----------------------------------------------------------------------------
// hcem_queue: two-entry command queue
// Decouples the input stage from the executing back end so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module hcem_queue
    import hcem_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hcem_hash.sv =====
// ----------------------------------------------------------------------------
// hcem_hash: iterative SplitMix64 finalizer
// Works out the user bucket with one shared 32x32 multiplier: each 64-bit
// constant multiply takes three partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module hcem_hash
    import hcem_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [UID_W-1:0]    user_id,
    output logic                     done,
    output logic [BUCKET_W-1:0]      bucket
);

    localparam int HALF_W = UID_W / 2;

    hash_state_t          state_reg, state_next;
    logic                 round_reg, round_next;
    logic [UID_W-1:0]     y_reg, y_next;
    logic [UID_W-1:0]     acc_reg, acc_next;
    logic [BUCKET_W-1:0]  bucket_reg, bucket_next;
    logic                 done_reg, done_next;

    logic [UID_W-1:0]     seed;
    logic [UID_W-1:0]     mul_const;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [UID_W-1:0]     prod;
    logic [UID_W-1:0]     mix_mid;
    logic [UID_W-1:0]     mix_post;

    // Shared multiplier and the xor-shift steps.
    always_comb begin
        seed      = user_id + GOLDEN_GAMMA;
        mul_const = round_reg ? MIX_MUL_2 : MIX_MUL_1;
        mul_a     = (state_reg == HS_MUL_HL) ? y_reg[UID_W-1:HALF_W] : y_reg[HALF_W-1:0];
        mul_b     = (state_reg == HS_MUL_LH) ? mul_const[UID_W-1:HALF_W]
                                             : mul_const[HALF_W-1:0];
        prod      = UID_W'(mul_a) * UID_W'(mul_b);
        mix_mid   = acc_reg ^ (acc_reg >> SHIFT_MID);
        mix_post  = acc_reg ^ (acc_reg >> SHIFT_POST);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            HS_IDLE:   if (start) state_next = HS_MUL_LL;
            HS_MUL_LL: state_next = HS_MUL_HL;
            HS_MUL_HL: state_next = HS_MUL_LH;
            HS_MUL_LH: state_next = HS_MIX;
            HS_MIX:    state_next = round_reg ? HS_IDLE : HS_MUL_LL;
            default:   state_next = HS_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        round_next  = round_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        bucket_next = bucket_reg;
        done_next   = 1'b0;
        case (state_reg)
            HS_IDLE: begin
                if (start) begin
                    y_next     = seed ^ (seed >> SHIFT_PRE);
                    round_next = 1'b0;
                end
            end
            HS_MUL_LL: begin
                acc_next = prod;
            end
            HS_MUL_HL, HS_MUL_LH: begin
                acc_next = {acc_reg[UID_W-1:HALF_W] + prod[HALF_W-1:0], acc_reg[HALF_W-1:0]};
            end
            HS_MIX: begin
                if (round_reg) begin
                    bucket_next = mix_post[UID_W-1:SHIFT_OUT];
                    done_next   = 1'b1;
                end else begin
                    y_next     = mix_mid;
                    round_next = 1'b1;
                end
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        round_reg  <= round_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

`default_nettype wire

// ===== rtl/hcem_back.sv =====
// ----------------------------------------------------------------------------
// hcem_back: command execution
// Writes event entries, runs the hash for queries, scans the active entries
// one per cycle and holds the finished result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcem_back
    import hcem_pkg::*;
#(
    parameter int NUM_EVENTS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [ACTIVE_W-1:0] active_events,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire cmd_t                cmd,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output result_t                  result
);

    // Only the entries an index can reach are stored; the rest stay zero.
    localparam int WRITABLE = (NUM_EVENTS < MAX_ENTRY) ? NUM_EVENTS : MAX_ENTRY;
    localparam int CNT_W    = $clog2(WRITABLE + 1);
    localparam int SEL_W    = (WRITABLE > 1) ? $clog2(WRITABLE) : 1;

    back_state_t          state_reg, state_next;

    logic [TRIG_W-1:0]    trig_reg [WRITABLE];
    logic [BOUND_W-1:0]   low_reg  [WRITABLE];
    logic [BOUND_W-1:0]   high_reg [WRITABLE];

    logic [COUNT_W-1:0]   count_reg;
    logic [BUCKET_W-1:0]  bucket_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 extra_reg;
    logic                 any_reg;
    logic                 applied_reg;
    logic [ENTRY_W-1:0]   match_reg;
    logic [TRIG_W-1:0]    min_reg;
    logic                 seen_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic                 out_free;
    logic                 take;
    logic                 take_write;
    logic                 take_query;
    logic                 write_hit;
    logic                 hash_done;
    logic [BUCKET_W-1:0]  hash_bucket;
    logic [CNT_W-1:0]     n_scan;
    logic                 n_extra;
    logic [CNT_W-1:0]     k_inc;
    logic [SEL_W-1:0]     sel;
    logic                 hit;
    logic [TRIG_W-1:0]    sel_trig;

    hcem_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (take_query),
        .user_id (cmd.user_id),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    // Active entry count clamped to the table, split into stored entries
    // and a flag for zero entries beyond them.
    always_comb begin
        n_scan  = (int'(active_events) > WRITABLE) ? CNT_W'(WRITABLE)
                                                   : CNT_W'(active_events);
        n_extra = (int'(active_events) > WRITABLE) && (NUM_EVENTS > WRITABLE);
    end

    // Entry under test in the scan.
    always_comb begin
        k_inc    = k_reg + 1'b1;
        sel      = k_reg[SEL_W-1:0];
        sel_trig = trig_reg[sel];
        hit      = ({1'b0, bucket_reg} >= low_reg[sel]) &&
                   ({1'b0, bucket_reg} < high_reg[sel]);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (take_query) state_next = BK_HASH;
            BK_HASH: begin
                if (hash_done) begin
                    state_next = (n_reg == '0) ? BK_EMIT : BK_SCAN;
                end
            end
            BK_SCAN: if (k_inc == n_reg) state_next = BK_EMIT;
            BK_EMIT: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        cmd_ready  = (state_reg == BK_IDLE) && out_free;
        take       = cmd_valid && cmd_ready;
        take_write = take && (cmd.action == ACT_WRITE);
        take_query = take && (cmd.action == ACT_QUERY);
        write_hit  = take_write && (int'(cmd.entry_index) < WRITABLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Event table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WRITABLE; i++) begin
                trig_reg[i] <= '0;
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
        end else if (write_hit) begin
            trig_reg[cmd.entry_index[SEL_W-1:0]] <= cmd.trigger_count;
            low_reg[cmd.entry_index[SEL_W-1:0]]  <= cmd.cohort_low;
            high_reg[cmd.entry_index[SEL_W-1:0]] <= cmd.cohort_high;
        end
    end

    // Query context and scan accumulators.
    always_ff @(posedge aclk) begin
        if (take_query) begin
            count_reg <= cmd.interaction_count;
            n_reg     <= n_scan;
            extra_reg <= n_extra;
        end
        if (state_reg == BK_HASH) begin
            bucket_reg  <= hash_bucket;
            k_reg       <= '0;
            any_reg     <= 1'b0;
            applied_reg <= 1'b0;
            match_reg   <= '0;
            min_reg     <= '0;
            seen_reg    <= 1'b0;
        end
        if (state_reg == BK_SCAN) begin
            k_reg <= k_inc;
            if (hit) begin
                any_reg <= 1'b1;
            end
            if (hit && (sel_trig == count_reg)) begin
                applied_reg <= 1'b1;
                match_reg   <= ENTRY_W'(sel);
            end
            if (!seen_reg || (sel_trig < min_reg)) begin
                min_reg  <= sel_trig;
                seen_reg <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take_write || (state_reg == BK_EMIT)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // A write result carries only the error flag, which is the top field.
    always_ff @(posedge aclk) begin
        if (take_write) begin
            out_reg <= result_t'({cmd.write_error, {($bits(result_t) - 1){1'b0}}});
        end else if (state_reg == BK_EMIT) begin
            out_reg.write_error      <= 1'b0;
            out_reg.user_bucket      <= bucket_reg;
            out_reg.earliest_trigger <= (seen_reg && !extra_reg) ? min_reg : '0;
            out_reg.in_any_cohort    <= any_reg;
            out_reg.matched_event    <= match_reg;
            out_reg.applied          <= applied_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

`default_nettype wire

// ===== rtl/hashed_cohort_event_matcher.sv =====
// A write result passes the input register, queue and output register; a query
// result also waits for the hash and the scan of the stored active entries
// (at most 8). Writes go one per cycle unless the output stalls; a query holds
// the back end until done. The hash shares a 32x32 multiplier (six partial
// products); the scan takes one entry per cycle. A synchronous active-low
// reset clears the event table, active count, queue and all state machines.
// ----------------------------------------------------------------------------
// hashed_cohort_event_matcher: hashed cohort drift event matcher
// Stores drift events and, for each user query, reports cohort membership,
// the firing event and the earliest trigger among the active events.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_cohort_event_matcher
    import hcem_pkg::*;
#(
    parameter int NUM_EVENTS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [ACTIVE_W-1:0] cfg_wr_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // entry_index, trigger_count, cohort_low, cohort_high, user_id,
    // interaction_count, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // action
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // applied, matched_event, in_any_cohort, earliest_trigger, user_bucket,
    // write_error, zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic [ACTIVE_W-1:0] active_reg;
    logic                front_valid;
    logic                front_ready;
    cmd_t                front_cmd;
    logic                queue_valid;
    logic                queue_ready;
    cmd_t                queue_cmd;
    result_t             result;

    // Active event count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    hcem_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    hcem_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    hcem_back #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .active_events (active_reg),
        .cmd_valid     (queue_valid),
        .cmd_ready     (queue_ready),
        .cmd           (queue_cmd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result        (result)
    );

    // Pack the result word, last result_t field in the lowest bits, zero pad on top.
    assign m_tdata = {{(M_DATA_W - $bits(result_t)){1'b0}}, result};

endmodule

`default_nettype wire
